@@ rtl/strong_coupling_row_filter_macros.svh @@
// assertion helpers shared by the row filter modules
// every use expects signals named clk and rst in scope
`ifndef STRONG_COUPLING_ROW_FILTER_MACROS_SVH
`define STRONG_COUPLING_ROW_FILTER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/scrf_pkg.sv @@
`timescale 1ns / 1ps

package scrf_pkg;

  // row buffer geometry
  localparam int ROW_MAX    = 32;
  localparam int INDEX_BITS = 16;
  localparam int CNT_W      = $clog2(ROW_MAX + 1);
  localparam int ADDR_W     = $clog2(ROW_MAX);

  // field widths
  localparam int COL_W   = 16;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int ENTRY_W = COL_W + VAL_W;

  // arithmetic widths
  localparam int SUM_W  = VAL_W + $clog2(ROW_MAX) + 1;
  localparam int EXT_W  = VAL_W + 1;
  localparam int PROD_W = 50;
  localparam int CMP_W  = SUM_W + FRAC_W;

  localparam logic [COL_W-1:0] IDX_MASK = COL_W'((64'd1 << INDEX_BITS) - 64'd1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int THR_W      = 16;
  localparam int MRS_W      = 18;

  localparam logic [MRS_W-1:0] MRS_ONE       = MRS_W'(65536);
  localparam logic [THR_W-1:0] THR_RESET     = THR_W'(16384);
  localparam logic [MRS_W-1:0] MRS_RESET     = MRS_W'(58982);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_ROW_SUM   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_SCALED = 2'd0,
    MODE_NEG    = 2'd1,
    MODE_ABS    = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [THR_W-1:0] eps_ratio;
    logic [MRS_W-1:0] sum_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [COL_W-1:0]        column;
  } entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_TAIL,
    S_MUL,
    S_CMP,
    S_RD,
    S_EV,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              wr_entry;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              scan_acc;
    logic              calc_mul;
    logic              calc_weak;
    logic              eval;
    logic              finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             eval_hold;
    logic             out_free;
  } dp_status_t;

endpackage

@@ rtl/scrf_ram.sv @@
`timescale 1ns / 1ps

module scrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/scrf_dp.sv @@
`timescale 1ns / 1ps
`include "strong_coupling_row_filter_macros.svh"

module scrf_dp import scrf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic [COL_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COL_W-1:0]        out_column,
  output logic                    out_is_strong,
  output logic                    out_overflow,
  output logic                    out_last
);

  logic [CNT_W-1:0]        entry_count;
  logic signed [SUM_W-1:0] running_sum;
  logic                    overflow_seen;
  logic [COL_W-1:0]        row_reg;
  logic signed [EXT_W-1:0] running_extreme;
  logic signed [VAL_W-1:0] diagonal_value;
  logic                    diag_found;
  logic [PROD_W-1:0]       weak_prod;
  logic signed [PROD_W-1:0] thr;
  logic                    row_weak;
  logic                    pend_valid;
  logic [COL_W-1:0]        pend_col;

  mode_t                   m;
  logic                    full;
  entry_t                  wr_entry_data;
  entry_t                  rd_entry;
  logic                    rd_diag;
  logic signed [EXT_W-1:0] rd_ext;
  logic signed [EXT_W-1:0] rd_neg;
  logic signed [EXT_W-1:0] rd_abs;
  logic signed [EXT_W-1:0] rd_cand;
  logic signed [EXT_W-1:0] diag_ext;
  logic [VAL_W-1:0]        diag_mag;
  logic signed [THR_W:0]   eps_s;
  logic [PROD_W-1:0]       weak_prod_next;
  logic signed [PROD_W-1:0] thr_next;
  logic [SUM_W-1:0]        sum_mag;
  logic [CMP_W-1:0]        sum_scaled;
  logic                    row_weak_next;
  logic signed [PROD_W-1:0] e_sh;
  logic signed [PROD_W-1:0] neg_sh;
  logic signed [PROD_W-1:0] abs_sh;
  logic                    strong_raw;
  logic                    rd_strong;
  logic                    out_free;
  logic                    load_mid;

  // reserved mode code behaves as scaled minimum
  assign m = (cfg.mode == MODE_RSVD) ? MODE_SCALED : cfg.mode;

  // row buffer
  assign full                 = (entry_count == CNT_W'(ROW_MAX));
  assign wr_entry_data.value  = in_value;
  assign wr_entry_data.column = in_col & IDX_MASK;

  scrf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ROW_MAX)
  ) u_row_ram (
    .clk  (clk),
    .we   (cmd.wr_entry && !full),
    .waddr(entry_count[ADDR_W-1:0]),
    .wdata(wr_entry_data),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr),
    .rdata(rd_entry)
  );

  // per-entry terms from the read data
  assign rd_diag = (rd_entry.column == row_reg);
  assign rd_ext  = {rd_entry.value[VAL_W-1], rd_entry.value};
  assign rd_neg  = -rd_ext;
  assign rd_abs  = rd_ext[EXT_W-1] ? rd_neg : rd_ext;
  assign rd_cand = (m == MODE_NEG) ? rd_neg : rd_abs;

  // row statistics products
  assign diag_ext       = {diagonal_value[VAL_W-1], diagonal_value};
  assign diag_mag       = diag_ext[EXT_W-1] ? VAL_W'(-diag_ext) : VAL_W'(diag_ext);
  assign eps_s          = $signed({1'b0, cfg.eps_ratio});
  assign weak_prod_next = PROD_W'(cfg.sum_limit) * PROD_W'(diag_mag);
  assign thr_next       = PROD_W'(eps_s) * PROD_W'(running_extreme);

  // row-sum test against the scaled diagonal
  assign sum_mag       = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  assign sum_scaled    = {sum_mag, {FRAC_W{1'b0}}};
  assign row_weak_next = (m == MODE_SCALED) && (cfg.sum_limit < MRS_ONE) &&
                         (sum_scaled > CMP_W'(weak_prod));

  // strength test of one buffered entry
  assign e_sh   = PROD_W'(rd_ext) <<< FRAC_W;
  assign neg_sh = PROD_W'(rd_neg) <<< FRAC_W;
  assign abs_sh = PROD_W'(rd_abs) <<< FRAC_W;

  always_comb begin
    case (m)
      MODE_NEG: strong_raw = (neg_sh >= thr);
      MODE_ABS: strong_raw = (abs_sh >= thr);
      default:  strong_raw = !row_weak && (e_sh < thr);
    endcase
  end

  assign rd_strong = strong_raw && !rd_diag;

  // status back to the controller
  assign out_free         = !out_valid || out_ready;
  assign status.count     = entry_count;
  assign status.out_free  = out_free;
  assign status.eval_hold = rd_strong && pend_valid && !out_free;

  // row state: load, scan, statistics
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      entry_count     <= '0;
      running_sum     <= '0;
      overflow_seen   <= 1'b0;
      running_extreme <= '0;
      diagonal_value  <= '0;
      diag_found      <= 1'b0;
      row_weak        <= 1'b0;
    end else begin
      if (cmd.wr_entry) begin
        if (!full) begin
          entry_count <= entry_count + 1'b1;
          running_sum <= running_sum + SUM_W'(in_value);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.scan_acc) begin
        if (rd_diag && !diag_found) begin
          diagonal_value <= rd_entry.value;
          diag_found     <= 1'b1;
        end
        if (m == MODE_SCALED) begin
          if (rd_ext < running_extreme) begin
            running_extreme <= rd_ext;
          end
        end else if (!rd_diag && (rd_cand > running_extreme)) begin
          running_extreme <= rd_cand;
        end
      end
      if (cmd.calc_weak) begin
        row_weak <= row_weak_next;
      end
    end
  end

  // row index of the final entry and the registered products
  always_ff @(posedge clk) begin
    if (cmd.wr_entry && in_last) begin
      row_reg <= in_row & IDX_MASK;
    end
    if (cmd.calc_mul) begin
      weak_prod <= weak_prod_next;
      thr       <= thr_next;
    end
  end

  // one strong column held back until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      pend_valid <= 1'b0;
    end else if (cmd.eval && rd_strong) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && rd_strong) begin
      pend_col <= rd_entry.column;
    end
  end

  // output register
  assign load_mid = cmd.eval && rd_strong && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_mid || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid) begin
      out_column    <= pend_col;
      out_is_strong <= 1'b1;
      out_overflow  <= overflow_seen;
      out_last      <= 1'b0;
    end else if (cmd.finish) begin
      out_column    <= pend_valid ? pend_col : '0;
      out_is_strong <= pend_valid;
      out_overflow  <= overflow_seen;
      out_last      <= 1'b1;
    end
  end

  `SCRF_ASSERT_SAME(a_mid_load_has_room, load_mid, out_free, "strong result loaded into busy output")
  `SCRF_ASSERT_NEXT(a_row_cleared, cmd.finish, (entry_count == '0) && !overflow_seen && !pend_valid, "row state not cleared after finish")

endmodule

@@ rtl/scrf_ctrl.sv @@
`timescale 1ns / 1ps
`include "strong_coupling_row_filter_macros.svh"

module scrf_ctrl import scrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_last,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [CNT_W-1:0] idx_inc;
  logic             at_end;
  logic             scan_vld;

  assign idx_inc = idx + 1'b1;
  assign at_end  = (idx_inc == status.count);

  // state, entry index and scan read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      idx      <= '0;
      scan_vld <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      scan_vld <= (state == S_SCAN);
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.rd_addr = idx[ADDR_W-1:0];
    unique case (state)
      S_LOAD: begin
        in_ready     = 1'b1;
        cmd.wr_entry = in_valid;
        if (in_valid && in_last) begin
          state_next = S_SCAN;
          idx_next   = '0;
        end
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.scan_acc = scan_vld;
        if (at_end) begin
          state_next = S_TAIL;
          idx_next   = '0;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_TAIL: begin
        cmd.scan_acc = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        cmd.calc_weak = 1'b1;
        state_next    = S_RD;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        if (!status.eval_hold) begin
          cmd.eval = 1'b1;
          if (at_end) begin
            state_next = S_FIN;
            idx_next   = '0;
          end else begin
            idx_next   = idx_inc;
            state_next = S_RD;
          end
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  `SCRF_ASSERT_NEXT(a_last_starts_scan, in_valid && in_ready && in_last, state == S_SCAN, "final entry did not start the scan")
  `SCRF_ASSERT_SAME(a_idx_in_row, (state == S_SCAN) || (state == S_RD) || (state == S_EV), idx < status.count, "entry index beyond buffered row")

endmodule

@@ rtl/strong_coupling_row_filter.sv @@
`timescale 1ns / 1ps
// Strong coupling row filter. Sparse matrix entries arrive on the s_axis
// channel one per transaction; s_axis_tlast marks the final entry of a row.
// The block buffers up to 32 entries (later ones are dropped and the row is
// flagged), then emits on m_axis one transaction per strong off-diagonal
// coupling in arrival order, or one marker with is_strong low when none is
// strong. m_axis_tlast marks the final result of the row.
// Steps: s_axis_tready is held high while loading. After the final entry
// the row is scanned (one buffer read per entry), the threshold and
// row-sum products are formed, each entry is emitted as a buffer read
// and then a test, and a closing step ends the row. A result reaches the
// output register only once the next strong coupling or the closing step
// shows whether it is last. No new row is taken until the previous one is
// fully handed to the output register. A stalled receiver holds the output
// register and emission waits; the last result of a row may wait there
// while the next row loads. Reset (rst, synchronous) empties the row and
// restores the register defaults: mode 1, threshold 16384, row-sum limit
// 58982. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block does not enforce this.

module strong_coupling_row_filter import scrf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // row_index, column, value
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // strong_column
  output logic [1:0]            m_axis_tuser,  // is_strong, row_overflow
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       out_is_strong;
  logic       out_overflow;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_NEG;
      cfg.eps_ratio <= THR_RESET;
      cfg.sum_limit <= MRS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      cfg.mode      <= mode_t'(cfg_data[1:0]);
        REG_THRESHOLD: cfg.eps_ratio <= cfg_data[THR_W-1:0];
        REG_ROW_SUM:   cfg.sum_limit <= cfg_data[MRS_W-1:0];
        default:       ;
      endcase
    end
  end

  scrf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_last (s_axis_tlast),
    .status  (status),
    .cmd     (cmd)
  );

  scrf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .in_row       (s_axis_tdata[15:0]),
    .in_col       (s_axis_tdata[31:16]),
    .in_value     (s_axis_tdata[63:32]),
    .in_last      (s_axis_tlast),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_column   (m_axis_tdata),
    .out_is_strong(out_is_strong),
    .out_overflow (out_overflow),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tuser = {out_overflow, out_is_strong};

endmodule
